FILE: src/bied_pkg.sv
// ----------------------------------------------------------------------------
// bied_pkg
// Shared constants and types for the binary image edge detector.
// ----------------------------------------------------------------------------
package bied_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WREG_W     = 8;
    localparam int HREG_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int OFIFO_AW    = 2;
    localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

    // one line buffer entry: pixel two rows up and one row up
    typedef struct packed {
        logic upper;
        logic middle;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    typedef struct packed {
        logic frame_last;
        logic row_last;
        logic edge_res;
    } res_t;

endpackage

FILE: src/bied_ram.sv
// ----------------------------------------------------------------------------
// bied_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bied_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bied_ofifo.sv
// ----------------------------------------------------------------------------
// bied_ofifo
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
module bied_ofifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bied_pkg::res_t push_data,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output bied_pkg::res_t out_data
);

    import bied_pkg::*;

    res_t                entries [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] wr_ptr_reg;
    logic [OFIFO_AW-1:0] rd_ptr_reg;
    logic [OFIFO_AW:0]   count_reg;
    logic [OFIFO_AW:0]   count_next;
    logic                pop;

    assign pop       = out_valid & out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    // one word may still be in flight behind the input handshake
    assign room      = (count_reg < (OFIFO_AW+1)'(OFIFO_DEPTH - 1));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (OFIFO_AW+1)'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - (OFIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OFIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OFIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/bied_core.sv
// ----------------------------------------------------------------------------
// bied_core
// Raster counters, line buffer RAM and the edge decision pipeline.
// ----------------------------------------------------------------------------
module bied_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bied_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bied_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_cmd,
    input  logic                                 in_pix,
    output logic                                 in_ready,
    input  logic                                 fifo_room,
    output logic                                 res_push,
    output bied_pkg::res_t                       res
);

    import bied_pkg::*;

    // configuration
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [COL_W-1:0]  wlast;
    logic [ROW_W-1:0]  hlast;

    // raster position (column also serves as drain position)
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              done_reg;

    // prefetched entry of the next column and its left neighbor
    logic              ok_reg;
    logic              pend_reg;
    line_t             cur_reg;
    logic              left_reg;

    // accept stage
    logic              a_valid_reg;
    logic              a_drain_reg;
    logic              a_pix_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic              a_emit_reg;
    logic              a_last_reg;
    logic              a_up_ok_reg;
    logic              a_left_ok_reg;

    // RAM and forwarding
    logic [COL_W-1:0]  rd_addr;
    logic [LINE_W-1:0] ram_q;
    line_t             rdata_f;
    logic              ram_we;
    line_t             ram_wdata;
    logic              fwd_hit_reg;
    line_t             fwd_data_reg;
    logic [COL_W-1:0]  rd_addr_q_reg;

    logic              in_fire;
    logic              take;
    logic              is_last;
    logic              is_drain;
    logic              clear_nb;

    always_comb
    begin
        if (width_reg == '0)
        begin
            wlast = '0;
        end
        else if (width_reg > WREG_W'(MAX_WIDTH))
        begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = COL_W'(width_reg - WREG_W'(1));
        end

        if (height_reg == '0)
        begin
            hlast = '0;
        end
        else if (height_reg > HREG_W'(MAX_HEIGHT))
        begin
            hlast = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            hlast = ROW_W'(height_reg - HREG_W'(1));
        end
    end

    assign in_ready = ok_reg & fifo_room;
    assign in_fire  = in_valid & in_ready;
    assign is_drain = (in_cmd == CMD_DRAIN);
    // pixels count only before the frame ends, drains only after
    assign take     = in_fire & (is_drain == done_reg);
    assign is_last  = (col_reg == wlast);

    // read one column ahead; while reloading read the current column
    always_comb
    begin
        if (!ok_reg)
        begin
            rd_addr = col_reg;
        end
        else if (is_last)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = col_reg + COL_W'(1);
        end
    end

    assign ram_we    = a_valid_reg & ~a_drain_reg;
    assign ram_wdata = '{upper: cur_reg.middle, middle: a_pix_reg};
    assign rdata_f   = fwd_hit_reg ? fwd_data_reg : line_t'(ram_q);

    bied_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_col_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        clear_nb = (a_up_ok_reg & ~cur_reg.upper)
                 | (a_left_ok_reg & ~left_reg)
                 | (~a_last_reg & ~rdata_f.middle)
                 | (~a_drain_reg & ~a_pix_reg);
    end

    assign res_push       = a_valid_reg & a_emit_reg;
    assign res.edge_res   = cur_reg.middle & clear_nb;
    assign res.row_last   = a_last_reg;
    assign res.frame_last = a_last_reg & a_drain_reg;

    always_ff @(posedge clk)
    begin
        fwd_data_reg  <= ram_wdata;
        rd_addr_q_reg <= rd_addr;
        if (take)
        begin
            a_drain_reg   <= is_drain;
            a_pix_reg     <= in_pix;
            a_col_reg     <= col_reg;
            a_emit_reg    <= is_drain | (row_reg != '0);
            a_last_reg    <= is_last;
            a_up_ok_reg   <= is_drain ? (hlast != '0) : (row_reg > ROW_W'(1));
            a_left_ok_reg <= (col_reg != '0);
        end
        if (a_valid_reg)
        begin
            left_reg <= cur_reg.middle;
            // one-column image: the entry just written is the next one
            if (ram_we && (rd_addr_q_reg == a_col_reg))
            begin
                cur_reg <= ram_wdata;
            end
            else
            begin
                cur_reg <= rdata_f;
            end
        end
        else if (!ok_reg && pend_reg)
        begin
            cur_reg <= rdata_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WREG_W'(MAX_WIDTH);
            height_reg  <= HREG_W'(MAX_HEIGHT);
            col_reg     <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= take;
            fwd_hit_reg <= ram_we && (a_col_reg == rd_addr);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WREG_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HREG_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
                col_reg  <= '0;
                row_reg  <= '0;
                done_reg <= 1'b0;
                ok_reg   <= 1'b0;
                pend_reg <= 1'b0;
            end
            else
            begin
                if (!ok_reg)
                begin
                    if (pend_reg)
                    begin
                        ok_reg   <= 1'b1;
                        pend_reg <= 1'b0;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                    end
                end
                if (take)
                begin
                    if (!is_last)
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                    else
                    begin
                        col_reg <= '0;
                        if (is_drain)
                        begin
                            row_reg  <= '0;
                            done_reg <= 1'b0;
                        end
                        else if (row_reg == hlast)
                        begin
                            row_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: src/binary_image_edge_detect_top.sv
// ----------------------------------------------------------------------------
// binary_image_edge_detect_top
// Edge flags for a binary raster image, 4-neighbour boundary test.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ group: s_tuser is the command (pixel or drain),
// s_tdata[0] the pixel. Result words leave on the m_ group with the edge flag,
// the row-end mark on m_tlast and the frame-end mark on m_tuser.
// The pixel word at row r, column c yields the result for row r-1, column c;
// row 0 yields nothing. Once the frame is complete, one drain word per column
// flushes the last row, the final one carrying the frame-end mark. Pixels
// sent while waiting for drains, and drains sent mid-frame, are dropped.
// Throughput is one word per clock while s_tready is high. The result of a
// taken word passes the edge decision stage, which works on the line buffer
// entry prefetched one column ahead, and is then written into the result
// queue, which raises m_tvalid. The line buffer holds two 1-bit lines in a
// single RAM entry per column.
// After reset, and after any configuration write, s_tready stays low while
// the current column entry is reloaded; the position returns to the start of
// a frame, line contents are kept.
// A four-word result queue absorbs m_tready stalls; s_tready drops once it
// holds three words, and rises again as soon as words drain.
// ----------------------------------------------------------------------------
module binary_image_edge_detect_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bied_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bied_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] pixel
    input  logic                                s_tuser,   // [0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [0] edge_res
    output logic                                m_tlast,   // row_last
    output logic                                m_tuser    // [0] frame_last
);

    import bied_pkg::*;

    logic fifo_room;
    logic res_push;
    res_t res;
    res_t out_res;

    bied_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_pix    (s_tdata[0]),
        .in_ready  (s_tready),
        .fifo_room (fifo_room),
        .res_push  (res_push),
        .res       (res)
    );

    bied_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .room      (fifo_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'd0, out_res.edge_res};
    assign m_tlast = out_res.row_last;
    assign m_tuser = out_res.frame_last;

endmodule

FILE: tb/bied_boundary_checker.sv
// ----------------------------------------------------------------------------
// bied_boundary_checker
// Watches the edge detector's channels, predicts each result word and
// compares it field by field.
// ----------------------------------------------------------------------------
// Keeps its own copy of the two line buffers, the raster position and the
// size registers. Every accepted input word steps that copy; a word that yields
// a result pushes the expected flags onto a queue. Every accepted output word
// is checked against the oldest entry.
// ----------------------------------------------------------------------------
module bied_boundary_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bied_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bied_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser,
    output int                              fail_count,
    output int                              pending,
    output int                              words_in,
    output int                              results_seen,
    output int                              frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bied_pkg::*;

    logic              upper_row [MAX_WIDTH];
    logic              middle_row [MAX_WIDTH];
    int                col;
    int                row;
    int                drain_col;
    bit                done_flag;
    logic              left_pix;
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    res_t              boundary_q [$];

    function automatic int width_now();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int height_now();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function automatic void restart_frame();
        col       = 0;
        row       = 0;
        drain_col = 0;
        done_flag = 1'b0;
        left_pix  = 1'b0;
    endfunction

    // advance the raster position by one input word, queue the flags it yields
    function automatic void boundary_step(logic cmd, logic pix);
        int   w;
        int   h;
        int   c;
        logic centre;
        logic nb_clear;
        res_t r;
        w = width_now();
        h = height_now();
        if (cmd == CMD_DRAIN) begin
            c = drain_col;
            if (!done_flag || c >= w) return;
            centre   = middle_row[c];
            nb_clear = 1'b0;
            if (h >= 2 && !upper_row[c]) nb_clear = 1'b1;
            if (c >= 1 && !middle_row[c-1]) nb_clear = 1'b1;
            if (c + 1 < w && !middle_row[c+1]) nb_clear = 1'b1;
            r.edge_res   = centre & nb_clear;
            r.row_last   = (c + 1 >= w);
            r.frame_last = r.row_last;
            boundary_q.push_back(r);
            if (r.frame_last) restart_frame();
            else drain_col = c + 1;
        end else begin
            c = col;
            if (done_flag || c >= w || row >= h) return;
            centre = middle_row[c];
            if (row >= 1) begin
                // the incoming pixel is the lower neighbour of the middle row
                nb_clear = !pix;
                if (row >= 2 && !upper_row[c]) nb_clear = 1'b1;
                if (c >= 1 && !left_pix) nb_clear = 1'b1;
                if (c + 1 < w && !middle_row[c+1]) nb_clear = 1'b1;
                r.edge_res   = centre & nb_clear;
                r.row_last   = (c + 1 >= w);
                r.frame_last = 1'b0;
                boundary_q.push_back(r);
            end
            left_pix      = centre;
            upper_row[c]  = centre;
            middle_row[c] = pix;
            col = c + 1;
            if (col >= w) begin
                col = 0;
                row = row + 1;
                if (row >= h) begin
                    row       = 0;
                    done_flag = 1'b1;
                    drain_col = 0;
                end
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t checker: %s got %0h expected %0h at result word %0d",
                 $time, what, got, want, results_seen);
        fail_count++;
    endtask

    task automatic check_word();
        res_t want;
        results_seen++;
        if (boundary_q.size() == 0) begin
            report_mismatch("result word with nothing expected", m_tdata, 8'h00);
            return;
        end
        want = boundary_q.pop_front();
        if (m_tdata[0] !== want.edge_res)
            report_mismatch("edge_res", 8'(m_tdata[0]), 8'(want.edge_res));
        if (m_tdata[7:1] !== 7'd0)
            report_mismatch("tdata padding", m_tdata, 8'h00);
        if (m_tlast !== want.row_last)
            report_mismatch("row_last", 8'(m_tlast), 8'(want.row_last));
        if (m_tuser !== want.frame_last)
            report_mismatch("frame_last", 8'(m_tuser), 8'(want.frame_last));
        if (want.frame_last) frames_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            width_reg  = WREG_W'(MAX_WIDTH);
            height_reg = HREG_W'(MAX_HEIGHT);
            restart_frame();
            boundary_q.delete();
            fail_count   = 0;
            words_in     = 0;
            results_seen = 0;
            frames_seen  = 0;
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data[WREG_W-1:0];
                else height_reg = cfg_data[HREG_W-1:0];
                restart_frame();
            end
            if (s_tvalid && s_tready)
            begin
                words_in++;
                boundary_step(s_tuser, s_tdata[0]);
            end
            if (m_tvalid && m_tready) check_word();
            pending = boundary_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the binary image edge detector.
// ----------------------------------------------------------------------------
// Streams raster frames of random binary pixels at many image sizes, clamped
// sizes included, with drain words to flush the last row, dropped words and
// abandoned frames. Both stream sides idle at random; once the output side
// holds off for a long stretch so the input backs up. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bied_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = CMD_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int fail_count;
    int pending;
    int words_in;
    int results_seen;
    int frames_seen;

    bit src_quiet   = 1'b0;
    bit sink_quiet  = 1'b0;
    bit squeeze_req = 1'b0;
    bit sink_hold   = 1'b0;
    int words_offered = 0;
    int frame_w;
    int frame_h;

    binary_image_edge_detect_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    bied_boundary_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_in     (words_in),
        .results_seen (results_seen),
        .frames_seen  (frames_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: random gap before each word, plus the long hold-off
    initial
    begin : result_sink
        int gap;
        gap = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || sink_hold) m_tready <= 1'b0;
            else if (gap > 0)
            begin
                m_tready <= 1'b0;
                gap--;
            end
            else m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready) gap = sink_quiet ? 0 : $urandom_range(0, 11);
        end
    end

    initial
    begin : sink_squeeze
        wait (squeeze_req);
        sink_hold = 1'b1;
        repeat (120) @(posedge clk);
        sink_hold = 1'b0;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int clamp_size(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // returns right after the edge at which the word was taken
    task automatic offer_word(logic cmd, logic pix);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, pix};
        do @(posedge clk); while (!s_tready);
        words_offered++;
    endtask

    // all results in, then a settling wait for words that yield none
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_size(int wv, int hv);
        logic [CFG_DATA_W-1:0] wword;
        // bits above the width register are don't-care
        wword = {3'($urandom_range(0, 7)), 8'(wv)};
        wait_quiet();
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_IMAGE_WIDTH, wword);
            write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
        end
        else
        begin
            write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
            write_reg(CFG_IMAGE_WIDTH, wword);
        end
        frame_w = clamp_size(wv, MAX_WIDTH);
        frame_h = clamp_size(hv, MAX_HEIGHT);
    endtask

    // npix below the frame size abandons the frame before any drain
    task automatic run_frame(int density, int npix, bit noise);
        for (int i = 0; i < npix; i++)
        begin
            if (noise && $urandom_range(0, 29) == 0)
                offer_word(CMD_DRAIN, 1'($urandom_range(0, 1)));
            offer_word(CMD_PIXEL, $urandom_range(0, 99) < density);
        end
        if (npix < frame_w * frame_h) return;
        for (int i = 0; i < frame_w; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
                offer_word(CMD_PIXEL, 1'($urandom_range(0, 1)));
            offer_word(CMD_DRAIN, 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic int pick_density();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 100;
            2: return 15;
            3: return 85;
            default: return 50;
        endcase
    endfunction

    initial
    begin : stimulus
        int corner_w [4];
        int corner_h [4];
        int base;
        int nframes;
        bit cut;
        int npix;

        corner_w = '{255, 128, 1, 200};
        corner_h = '{1, 2, 2047, 3};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset size: a partial row, then a drain that comes too early
        offer_word(CMD_PIXEL, 1'b1);
        offer_word(CMD_PIXEL, 1'b1);
        offer_word(CMD_PIXEL, 1'b0);
        offer_word(CMD_DRAIN, 1'b0);

        // zero sizes clamp to a single pixel; a pixel while waiting is dropped
        set_size(0, 0);
        offer_word(CMD_PIXEL, 1'b1);
        offer_word(CMD_PIXEL, 1'b0);
        offer_word(CMD_DRAIN, 1'b1);

        // solid 2x2: no boundary anywhere
        set_size(2, 2);
        repeat (4) offer_word(CMD_PIXEL, 1'b1);
        repeat (2) offer_word(CMD_DRAIN, 1'b0);

        // lone pixel in the middle of a 3x3
        set_size(3, 3);
        for (int i = 0; i < 9; i++) offer_word(CMD_PIXEL, i == 4);
        repeat (3) offer_word(CMD_DRAIN, 1'b0);

        // widest and tallest images, oversize values clamped
        foreach (corner_w[k])
        begin
            set_size(corner_w[k], corner_h[k]);
            src_quiet  = ($urandom_range(0, 2) == 0);
            sink_quiet = ($urandom_range(0, 2) == 0);
            run_frame(pick_density(), frame_w * frame_h, 1'b0);
        end

        // sender at full rate while the output side is held off
        set_size(16, 12);
        src_quiet   = 1'b1;
        sink_quiet  = 1'b0;
        squeeze_req = 1'b1;
        run_frame(50, frame_w * frame_h, 1'b0);

        base = words_offered;
        while (words_offered - base < 1200)
        begin
            set_size($urandom_range(1, 20), $urandom_range(1, 12));
            nframes = $urandom_range(1, 3);
            cut = 1'b0;
            for (int f = 0; f < nframes && !cut; f++)
            begin
                src_quiet  = ($urandom_range(0, 3) == 0);
                sink_quiet = ($urandom_range(0, 3) == 0);
                npix = frame_w * frame_h;
                if ($urandom_range(0, 9) == 0)
                begin
                    npix = $urandom_range(0, npix - 1);
                    cut  = 1'b1;
                end
                run_frame(pick_density(), npix, $urandom_range(0, 4) == 0);
            end
        end

        wait_quiet();
        repeat (10) @(posedge clk);
        $display("tb: %0d words taken, %0d result words checked, %0d frames closed",
                 words_in, results_seen, frames_seen);
        $display("tb: sizes 1x1 to 128 wide and 1024 tall, clamped sizes, dropped words,");
        $display("tb: abandoned frames and a long output stall with a full queue");
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
